[design/cxy_pkg.sv]
// ----------------------------------------------------------------------------
// cxy_pkg: shared constants, types and ramp table for the CoreXY time estimator
// Widths of the datapath, the ramp parameters and the cumulative ramp time
// ROM, built once at elaboration.
// ----------------------------------------------------------------------------
package cxy_pkg;

	// Move fields
	localparam int DX_W     = 15;
	localparam int SPD_W    = 14;
	localparam int MAG_W    = 16;                 // |motor move| up to 32768
	localparam int SQ_W     = 29;                 // dx*dx
	localparam int N_W      = 30;                 // dx*dx + dy*dy
	localparam int FRAC_W   = 16;
	localparam int SQV_W    = N_W + FRAC_W;       // radicand
	localparam int ROOT_W   = SQV_W / 2;
	localparam int SQ_REM_W = SQV_W + 2;
	localparam int TIME_W   = 32;

	// Ramp definition
	localparam int SPEED_SEGMENTS = 300;
	localparam int SEG_W          = $clog2(SPEED_SEGMENTS);
	localparam int START_SPEED    = 100;
	localparam int SPEED_STEP     = 50;
	localparam int RAMP_STEPS     = 14;
	localparam int RS2            = 2 * RAMP_STEPS;
	localparam int COS45_NUM      = 7071;
	localparam int COS45_DEN      = 10000;
	localparam int SEG_XMAX       = SPEED_STEP * (SPEED_SEGMENTS - 1);
	localparam int XC_W           = $clog2(SEG_XMAX + 1);
	localparam int SP_MAX         = START_SPEED + SPEED_STEP * (SPEED_SEGMENTS - 1);
	localparam int SP_W           = $clog2(SP_MAX + 1);

	// Reciprocals for the constant divisions (rounded up, exact over the used range)
	localparam int SEG_SHIFT  = 18;
	localparam int SEG_RECIP  = (2 ** SEG_SHIFT + SPEED_STEP - 1) / SPEED_STEP;
	localparam int SEG_RC_W   = $clog2(SEG_RECIP + 1);
	localparam int HALF_SHIFT = 20;
	localparam int HALF_RECIP = (2 ** HALF_SHIFT + RS2 - 1) / RS2;
	localparam int HALF_RC_W  = $clog2(HALF_RECIP + 1);

	// Pipelined divider
	localparam int DV_NUM_W = 59;
	localparam int DV_DEN_W = 37;
	localparam int DV_Q_W   = 25;
	localparam int DV_REM_W = DV_DEN_W + DV_Q_W;

	// Latencies
	localparam int LANE_LAT = 2 * DV_Q_W + 7;
	localparam int PIPE_LAT = 3 + ROOT_W + LANE_LAT;

	typedef logic [TIME_W-1:0] ramp_rom_t [SPEED_SEGMENTS];

	// Bit-serial long division for table building only
	function automatic logic [31:0] udiv_const(input logic [31:0] n, input logic [31:0] d);
		logic [31:0] q;
		logic [32:0] r;
		q = '0;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			r = {r[31:0], n[i]};
			if (r >= {1'b0, d}) begin
				r    = r - {1'b0, d};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// Cumulative ramp time in Q16.16, each segment term rounded half up
	function automatic ramp_rom_t build_ramp();
		ramp_rom_t   t;
		logic [31:0] sum;
		logic [31:0] sp;
		sum = '0;
		for (int j = 0; j < SPEED_SEGMENTS; j++) begin
			sp   = 32'(START_SPEED + SPEED_STEP * j);
			sum  = sum + udiv_const((32'(RAMP_STEPS) << FRAC_W) + (sp >> 1), sp);
			t[j] = sum;
		end
		return t;
	endfunction

	localparam ramp_rom_t RAMP_T = build_ramp();

endpackage

[design/cxy_sqrt.sv]
// ----------------------------------------------------------------------------
// cxy_sqrt: pipelined integer square root
// One result bit per stage, remainder form, floor(sqrt(value)).
// ----------------------------------------------------------------------------
module cxy_sqrt import cxy_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [SQV_W-1:0]  value,
	output logic [ROOT_W-1:0] root
);

	logic [SQ_REM_W-1:0] rem_s   [ROOT_W];
	logic [ROOT_W-1:0]   root_s  [ROOT_W];
	logic [SQ_REM_W-1:0] rem_in  [ROOT_W];
	logic [ROOT_W-1:0]   root_in [ROOT_W];
	logic [SQ_REM_W-1:0] trial   [ROOT_W];
	logic [ROOT_W-1:0]   take;

	always_comb begin
		rem_in[0]  = SQ_REM_W'(value);
		root_in[0] = '0;
		for (int g = 1; g < ROOT_W; g++) begin
			rem_in[g]  = rem_s[g-1];
			root_in[g] = root_s[g-1];
		end
		for (int g = 0; g < ROOT_W; g++) begin
			// (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
			trial[g] = (SQ_REM_W'(root_in[g]) << (ROOT_W - g))
				| (SQ_REM_W'(1) << (2 * (ROOT_W - 1 - g)));
			take[g]  = rem_in[g] >= trial[g];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < ROOT_W; g++) begin
				if (take[g]) begin
					rem_s[g]  <= rem_in[g] - trial[g];
					root_s[g] <= root_in[g] | (ROOT_W'(1) << (ROOT_W - 1 - g));
				end else begin
					rem_s[g]  <= rem_in[g];
					root_s[g] <= root_in[g];
				end
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

[design/cxy_div.sv]
// ----------------------------------------------------------------------------
// cxy_div: pipelined restoring divider
// One quotient bit per stage; the quotient must fit in DV_Q_W bits.
// ----------------------------------------------------------------------------
module cxy_div import cxy_pkg::*; (
	input  logic                clk,
	input  logic                en,
	input  logic [DV_NUM_W-1:0] num,
	input  logic [DV_DEN_W-1:0] den,
	output logic [DV_Q_W-1:0]   quo
);

	logic [DV_REM_W-1:0] rem_s  [DV_Q_W];
	logic [DV_DEN_W-1:0] den_s  [DV_Q_W];
	logic [DV_Q_W-1:0]   quo_s  [DV_Q_W];
	logic [DV_REM_W-1:0] rem_in [DV_Q_W];
	logic [DV_DEN_W-1:0] den_in [DV_Q_W];
	logic [DV_Q_W-1:0]   quo_in [DV_Q_W];
	logic [DV_REM_W-1:0] shf    [DV_Q_W];
	logic [DV_Q_W-1:0]   take;

	always_comb begin
		rem_in[0] = DV_REM_W'(num);
		den_in[0] = den;
		quo_in[0] = '0;
		for (int g = 1; g < DV_Q_W; g++) begin
			rem_in[g] = rem_s[g-1];
			den_in[g] = den_s[g-1];
			quo_in[g] = quo_s[g-1];
		end
		for (int g = 0; g < DV_Q_W; g++) begin
			shf[g]  = DV_REM_W'(den_in[g]) << (DV_Q_W - 1 - g);
			take[g] = rem_in[g] >= shf[g];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int g = 0; g < DV_Q_W; g++) begin
				den_s[g] <= den_in[g];
				if (take[g]) begin
					rem_s[g] <= rem_in[g] - shf[g];
					quo_s[g] <= quo_in[g] | (DV_Q_W'(1) << (DV_Q_W - 1 - g));
				end else begin
					rem_s[g] <= rem_in[g];
					quo_s[g] <= quo_in[g];
				end
			end
		end
	end

	assign quo = quo_s[DV_Q_W-1];

endmodule

[design/cxy_lane.sv]
// ----------------------------------------------------------------------------
// cxy_lane: run time of one motor
// Motor speed, ramp segment count, short-move cut, cruise time and ramp sum.
// ----------------------------------------------------------------------------
module cxy_lane import cxy_pkg::*; (
	input  logic              clk,
	input  logic              en,
	input  logic [MAG_W-1:0]  mag,
	input  logic [SPD_W-1:0]  speed,
	input  logic [ROOT_W-1:0] root,
	output logic [TIME_W-1:0] motor_time
);

	localparam int PROD_W = SPD_W + MAG_W;
	localparam int NUM_W  = PROD_W + 13;

	logic [PROD_W-1:0]   prod_s1;
	logic [DV_DEN_W-1:0] den_s1, den_s2;
	logic [MAG_W-1:0]    mag_s1, mag_s2, mag_s3, mag_s4, mag_s5;
	logic [NUM_W-1:0]    num_s2;
	logic [MAG_W-1:0]    magd_q [DV_Q_W];
	logic [DV_Q_W-1:0]   vq;
	logic [DV_Q_W:0]     vr;
	logic [DV_Q_W-8:0]   c;
	logic [XC_W-1:0]     xc, xc_s3;
	logic [MAG_W+HALF_RC_W-1:0] hprod;
	logic [MAG_W-1:0]    a28_s3, a28_s4;
	logic [XC_W+SEG_RC_W-1:0]   sprod;
	logic [SEG_W-1:0]    seg_s4, k_s5;
	logic [MAG_W-1:0]    cruise_steps;
	logic [SP_W-1:0]     sp, sp_s6;
	logic [TIME_W-1:0]   num2_s6;
	logic [TIME_W-1:0]   ramp_s6;
	logic [TIME_W-1:0]   rampd_q [DV_Q_W];
	logic [DV_Q_W-1:0]   cq;
	logic [TIME_W-1:0]   motor_time_s7;

	// Speed ratio: speed * |m| * 7071 * 2^16 / (10000 * root)
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PROD_W'(speed) * PROD_W'(mag);
			den_s1  <= DV_DEN_W'(root) * DV_DEN_W'(COS45_DEN);
			mag_s1  <= mag;
			num_s2  <= NUM_W'(prod_s1) * NUM_W'(COS45_NUM);
			den_s2  <= den_s1;
			mag_s2  <= mag_s1;
		end
	end

	cxy_div u_vdiv (
		.clk (clk),
		.en  (en),
		.num ({num_s2, FRAC_W'(0)}),
		.den (den_s2),
		.quo (vq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			magd_q[0] <= mag_s2;
			for (int i = 1; i < DV_Q_W; i++) begin
				magd_q[i] <= magd_q[i-1];
			end
		end
	end

	// Round the Q.8 speed up, then clamp into the segment range
	always_comb begin
		vr    = {1'b0, vq} + (DV_Q_W + 1)'(255);
		c     = vr[DV_Q_W:8];
		hprod = (MAG_W + HALF_RC_W)'(magd_q[DV_Q_W-1]) * (MAG_W + HALF_RC_W)'(HALF_RECIP);
		if (c < (DV_Q_W - 7)'(START_SPEED)) begin
			xc = '0;
		end else if (c - (DV_Q_W - 7)'(START_SPEED) >= (DV_Q_W - 7)'(SEG_XMAX)) begin
			xc = XC_W'(SEG_XMAX);
		end else begin
			xc = XC_W'(c - (DV_Q_W - 7)'(START_SPEED));
		end
	end

	assign sprod = (XC_W + SEG_RC_W)'(xc_s3) * (XC_W + SEG_RC_W)'(SEG_RECIP);

	always_ff @(posedge clk) begin
		if (en) begin
			xc_s3  <= xc;
			a28_s3 <= MAG_W'(hprod >> HALF_SHIFT);
			mag_s3 <= magd_q[DV_Q_W-1];
			seg_s4 <= SEG_W'(sprod >> SEG_SHIFT);
			a28_s4 <= a28_s3;
			mag_s4 <= mag_s3;
			// Cut the ramp short when up and down ramps would not fit the move
			if (MAG_W'(seg_s4) * MAG_W'(RS2) >= mag_s4) begin
				k_s5 <= a28_s4[SEG_W-1:0];
			end else begin
				k_s5 <= seg_s4;
			end
			mag_s5 <= mag_s4;
		end
	end

	assign cruise_steps = mag_s5 - MAG_W'(k_s5) * MAG_W'(RS2);
	assign sp           = SP_W'(START_SPEED) + SP_W'(k_s5) * SP_W'(SPEED_STEP);

	always_ff @(posedge clk) begin
		if (en) begin
			num2_s6 <= {cruise_steps, FRAC_W'(0)} + TIME_W'(sp >> 1);
			sp_s6   <= sp;
			ramp_s6 <= RAMP_T[k_s5];
		end
	end

	cxy_div u_cdiv (
		.clk (clk),
		.en  (en),
		.num (DV_NUM_W'(num2_s6)),
		.den (DV_DEN_W'(sp_s6)),
		.quo (cq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			rampd_q[0] <= ramp_s6;
			for (int i = 1; i < DV_Q_W; i++) begin
				rampd_q[i] <= rampd_q[i-1];
			end
			motor_time_s7 <= (rampd_q[DV_Q_W-1] << 1) + TIME_W'(cq);
		end
	end

	assign motor_time = motor_time_s7;

endmodule

[design/corexy_move_time_estimate.sv]
// ----------------------------------------------------------------------------
// corexy_move_time_estimate: CoreXY move run time estimator
// Per move, both motor lanes compute their run time in Q16.16 seconds and
// the slower motor's time is returned; a zero move returns zero.
// ----------------------------------------------------------------------------
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  in      | in_valid, in_ready, delta_x, delta_y,     | into block
//          | set_speed                                 |
//  out     | out_valid, out_ready, move_time           | out of block
//
// One move is taken every cycle while the pipeline advances; the path from input
// transfer to result valid runs through the two 25-stage lane dividers and the
// 23-stage square root.
// The whole pipeline advances together whenever the output register is
// empty or being drained; a stalled output holds every stage.
// Reset (arst_n low) clears the stage valid bits and the output valid.
// ----------------------------------------------------------------------------
module corexy_move_time_estimate import cxy_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [DX_W-1:0]   delta_x,
	input  logic signed [DX_W-1:0]   delta_y,
	input  logic [SPD_W-1:0]         set_speed,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [TIME_W-1:0]        move_time
);

	typedef struct packed {
		logic [MAG_W-1:0] mag1;
		logic [MAG_W-1:0] mag2;
		logic [SPD_W-1:0] spd;
		logic             zero;
	} side_t;

	logic                   adv;
	logic [PIPE_LAT-1:0]    vld_q;
	logic                   out_valid_q;
	logic [TIME_W-1:0]      move_time_q;

	logic signed [DX_W-1:0] dx_s1, dy_s1;
	logic [SPD_W-1:0]       spd_s1;
	logic signed [DX_W+1:0] m1, m2;
	logic signed [2*DX_W-1:0] sqx, sqy;
	logic [SQ_W-1:0]        sqx_s2, sqy_s2;
	side_t                  side_s2, side_s3, side;
	logic [N_W-1:0]         nsum_s3;
	side_t                  side_q [ROOT_W];
	logic [ROOT_W-1:0]      root;
	logic                   zero_q [LANE_LAT];
	logic [TIME_W-1:0]      t1, t2;

	// Advance the whole pipeline when the output slot is free or drained
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			vld_q       <= {vld_q[PIPE_LAT-2:0], in_valid};
			out_valid_q <= vld_q[PIPE_LAT-1];
		end
	end

	// Motor moves m1 = dx - dy, m2 = -dx - dy at full width, never wrapping
	always_comb begin
		m1         = (DX_W + 2)'(dx_s1) - (DX_W + 2)'(dy_s1);
		m2         = -(DX_W + 2)'(dx_s1) - (DX_W + 2)'(dy_s1);
		sqx        = (2 * DX_W)'(dx_s1) * (2 * DX_W)'(dx_s1);
		sqy        = (2 * DX_W)'(dy_s1) * (2 * DX_W)'(dy_s1);
		side.mag1  = m1[DX_W+1] ? MAG_W'(-m1) : MAG_W'(m1);
		side.mag2  = m2[DX_W+1] ? MAG_W'(-m2) : MAG_W'(m2);
		side.spd   = spd_s1;
		side.zero  = (dx_s1 == '0) && (dy_s1 == '0);
	end

	// Capture the move, square, then sum into the radicand
	always_ff @(posedge clk) begin
		if (adv) begin
			dx_s1   <= delta_x;
			dy_s1   <= delta_y;
			spd_s1  <= set_speed;
			sqx_s2  <= SQ_W'(sqx);
			sqy_s2  <= SQ_W'(sqy);
			side_s2 <= side;
			nsum_s3 <= N_W'(sqx_s2) + N_W'(sqy_s2);
			side_s3 <= side_s2;
		end
	end

	// Path length in Q.8: sqrt(N * 2^16)
	cxy_sqrt u_sqrt (
		.clk   (clk),
		.en    (adv),
		.value ({nsum_s3, FRAC_W'(0)}),
		.root  (root)
	);

	// Hold the move's side data alongside the root stages
	always_ff @(posedge clk) begin
		if (adv) begin
			side_q[0] <= side_s3;
			for (int i = 1; i < ROOT_W; i++) begin
				side_q[i] <= side_q[i-1];
			end
			zero_q[0] <= side_q[ROOT_W-1].zero;
			for (int i = 1; i < LANE_LAT; i++) begin
				zero_q[i] <= zero_q[i-1];
			end
		end
	end

	cxy_lane u_lane1 (
		.clk        (clk),
		.en         (adv),
		.mag        (side_q[ROOT_W-1].mag1),
		.speed      (side_q[ROOT_W-1].spd),
		.root       (root),
		.motor_time (t1)
	);

	cxy_lane u_lane2 (
		.clk        (clk),
		.en         (adv),
		.mag        (side_q[ROOT_W-1].mag2),
		.speed      (side_q[ROOT_W-1].spd),
		.root       (root),
		.motor_time (t2)
	);

	// Merge: keep the slower motor, force zero for a zero move
	always_ff @(posedge clk) begin
		if (adv) begin
			if (zero_q[LANE_LAT-1]) begin
				move_time_q <= '0;
			end else if (t1 > t2) begin
				move_time_q <= t1;
			end else begin
				move_time_q <= t2;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign move_time = move_time_q;

endmodule

[design/cxy_checker.sv]
// ----------------------------------------------------------------------------
// cxy_checker: port-level checks for the CoreXY time estimator
// Watches the handshake ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
module cxy_checker import cxy_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_valid,
	input logic                   in_ready,
	input logic signed [DX_W-1:0] delta_x,
	input logic signed [DX_W-1:0] delta_y,
	input logic [SPD_W-1:0]       set_speed,
	input logic                   out_valid,
	input logic                   out_ready,
	input logic [TIME_W-1:0]      move_time
);

	// A waiting result holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(move_time))
		else $error("result changed while stalled");

	// Input side stalls only behind a result that is not taken
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("in_ready does not follow the output slot");

	// A new result appears only through a pipeline advance
	a_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_ready))
		else $error("result appeared without pipeline advance");

endmodule

bind corexy_move_time_estimate cxy_checker u_cxy_checker (.*);
